// File: sv/rau_pkg.sv
// package: shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
	localparam int WIDTH = 32;
	localparam int MW = 64;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_CMP = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ERR  = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	// classified job handed from front to back
	typedef struct packed {
		logic          early;    // result already known, no arithmetic
		logic          is_eq;
		logic [1:0]    status;
		logic [2:0]    cmd;
		logic          an_neg;
		logic [31:0]   an_mag;
		logic          ad_neg;
		logic [31:0]   ad_mag;
		logic          bn_neg;
		logic [31:0]   bn_mag;
		logic          bd_neg;
		logic [31:0]   bd_mag;
	} job_t;

	typedef struct packed {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               is_eq;
		logic [1:0]         status;
	} res_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction
endpackage
`default_nettype wire

// File: sv/rau_front.sv
// front end: accepts beats, splits operands into sign and magnitude, flags errors
`default_nettype none
module rau_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] a_num,
	input  wire logic [31:0] a_den,
	input  wire logic [31:0] b_num,
	input  wire logic [31:0] b_den,
	output logic             job_valid,
	input  wire logic        job_stall,
	output rau_pkg::job_t    job
);
	import rau_pkg::*;

	job_t job_q;
	logic valid_q;
	job_t cls;

	assign in_stall  = valid_q && job_stall;
	assign job_valid = valid_q;
	assign job       = job_q;

	// classify the incoming beat
	always_comb begin
		cls = '0;
		cls.cmd    = command;
		cls.an_mag = mag32(a_num);
		cls.ad_mag = mag32(a_den);
		cls.bn_mag = mag32(b_num);
		cls.bd_mag = mag32(b_den);
		cls.an_neg = a_num[31] && (a_num != '0);
		cls.ad_neg = a_den[31];
		cls.bn_neg = b_num[31] && (b_num != '0);
		cls.bd_neg = b_den[31];
		if (command > 3'(CMD_CMP) || a_den == '0 || b_den == '0) begin
			cls.early = 1'b1;
			cls.status = ST_ERR;
		end else if (command == 3'(CMD_DIV) && b_num == '0) begin
			cls.early = 1'b1;
			cls.status = ST_ERR;
		end
	end

	// one-entry hold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			job_q <= cls;
		end
	end
endmodule
`default_nettype wire

// File: sv/rau_fifo.sv
// two-entry queue between front end and back end
`default_nettype none
module rau_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_valid,
	output logic              wr_stall,
	input  wire rau_pkg::job_t wr_data,
	output logic              rd_valid,
	input  wire logic         rd_take,
	output rau_pkg::job_t     rd_data
);
	import rau_pkg::*;

	job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule
`default_nettype wire

// File: sv/rau_back.sv
// back end: products, sum, gcd by binary steps, division by gcd, range check
`default_nettype none
module rau_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_take,
	input  wire rau_pkg::job_t job,
	output logic               out_valid,
	input  wire logic          out_stall,
	output rau_pkg::res_t      res
);
	import rau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_ADD, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT
	} state_t;

	localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

	state_t state_q;
	job_t j_q;
	logic [63:0] p1_q, p2_q;
	logic p1n_q, p2n_q;
	logic [63:0] num_q, den_q;
	logic numn_q, denn_q;
	logic [63:0] gx_q, gy_q;
	logic [6:0] sh_q;
	logic [63:0] g_q;
	logic [63:0] quo_q, rem_q, dvd_q;
	logic [6:0] cnt_q;
	logic [63:0] qn_q;
	res_t res_q;

	logic [63:0] mx, my, dx, dy, rtry;
	logic mneg_x, mneg_y;
	logic [63:0] prod;
	logic [63:0] gd;
	logic [63:0] rsh;

	assign out_valid = (state_q == S_OUT);
	assign res = res_q;
	assign job_take = (state_q == S_IDLE);

	// operand select for the shared multiplier
	always_comb begin
		mx = '0; my = '0; mneg_x = 1'b0; mneg_y = 1'b0;
		if (state_q == S_MUL1) begin
			unique case (j_q.cmd)
				3'(CMD_MUL): begin
					mx = 64'(j_q.an_mag); my = 64'(j_q.bn_mag);
					mneg_x = j_q.an_neg; mneg_y = j_q.bn_neg;
				end
				default: begin
					mx = 64'(j_q.an_mag); my = 64'(j_q.bd_mag);
					mneg_x = j_q.an_neg; mneg_y = j_q.bd_neg;
				end
			endcase
		end else begin
			unique case (j_q.cmd)
				3'(CMD_DIV): begin
					mx = 64'(j_q.ad_mag); my = 64'(j_q.bn_mag);
					mneg_x = j_q.ad_neg; mneg_y = j_q.bn_neg;
				end
				3'(CMD_CMP): begin
					mx = 64'(j_q.bn_mag); my = 64'(j_q.ad_mag);
					mneg_x = j_q.bn_neg; mneg_y = j_q.ad_neg;
				end
				3'(CMD_MUL): begin
					mx = 64'(j_q.ad_mag); my = 64'(j_q.bd_mag);
					mneg_x = j_q.ad_neg; mneg_y = j_q.bd_neg;
				end
				default: begin
					mx = 64'(j_q.bn_mag); my = 64'(j_q.ad_mag);
					mneg_x = j_q.bn_neg; mneg_y = j_q.ad_neg;
				end
			endcase
		end
		// magnitudes are at most 32 bits, full 64-bit product
		prod = 64'(mx[31:0]) * 64'(my[31:0]);
	end

	// binary gcd step values and the division trial remainder
	always_comb begin
		dx = gx_q;
		dy = gy_q;
		gd = (gx_q > gy_q) ? gx_q - gy_q : gy_q - gx_q;
		rsh = gx_q << sh_q[5:0];
		rtry = {rem_q[62:0], dvd_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						j_q <= job;
						if (job.early) begin
							res_q <= '{num: '0, den: '0, is_eq: 1'b0, status: job.status};
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					p1_q <= prod;
					p1n_q <= (prod != '0) && (mneg_x != mneg_y);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p2_q <= prod;
					p2n_q <= (prod != '0) && (mneg_x != mneg_y)
						^ ((j_q.cmd == 3'(CMD_SUB)) && (prod != '0));
					state_q <= S_ADD;
				end
				S_ADD: begin
					res_q <= '0;
					if (j_q.cmd == 3'(CMD_CMP)) begin
						res_q.is_eq <= (p1_q == p2_q) && (p1n_q == p2n_q);
						state_q <= S_OUT;
					end else begin
						if (j_q.cmd == 3'(CMD_MUL) || j_q.cmd == 3'(CMD_DIV)) begin
							num_q <= p1_q; numn_q <= p1n_q;
							den_q <= p2_q; denn_q <= p2n_q;
							gx_q <= p1_q; gy_q <= p2_q;
						end else begin
							den_q <= 64'(j_q.ad_mag) * 64'(j_q.bd_mag);
							denn_q <= j_q.ad_neg ^ j_q.bd_neg;
							if (p1n_q == p2n_q) begin
								num_q <= p1_q + p2_q; numn_q <= p1n_q;
								gx_q <= p1_q + p2_q;
							end else if (p1_q >= p2_q) begin
								num_q <= p1_q - p2_q; numn_q <= p1n_q;
								gx_q <= p1_q - p2_q;
							end else begin
								num_q <= p2_q - p1_q; numn_q <= p2n_q;
								gx_q <= p2_q - p1_q;
							end
							gy_q <= 64'(j_q.ad_mag) * 64'(j_q.bd_mag);
						end
						sh_q <= '0;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					// binary gcd: strip common twos, then subtract
					if (dx == '0) begin
						res_q.num <= '0;
						res_q.den <= 31'd1;
						state_q <= S_OUT;
					end else if (dx == dy) begin
						g_q <= rsh;
						quo_q <= '0; rem_q <= '0; dvd_q <= num_q; cnt_q <= '0;
						state_q <= S_DIVN;
					end else if (!dx[0] && !dy[0]) begin
						gx_q <= dx >> 1; gy_q <= dy >> 1; sh_q <= sh_q + 7'd1;
					end else if (!dx[0]) begin
						gx_q <= dx >> 1;
					end else if (!dy[0]) begin
						gy_q <= dy >> 1;
					end else if (dx > dy) begin
						gx_q <= gd >> 1;
					end else begin
						gy_q <= gd >> 1;
					end
				end
				S_DIVN, S_DIVD: begin
					// restoring division, one quotient bit per cycle
					dvd_q <= dvd_q << 1;
					if (rtry >= g_q) begin
						rem_q <= rtry - g_q; quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rtry; quo_q <= {quo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) begin
						cnt_q <= '0;
						if (state_q == S_DIVN) begin
							qn_q <= {quo_q[62:0], rtry >= g_q};
							rem_q <= '0; quo_q <= '0; dvd_q <= den_q;
							state_q <= S_DIVD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (quo_q > LIM || qn_q > LIM + 64'(numn_q != denn_q)) begin
						res_q.status <= ST_OVF;
						res_q.num <= '0; res_q.den <= '0;
					end else begin
						res_q.num <= (numn_q != denn_q) ? 32'(~qn_q + 64'd1) : qn_q[31:0];
						res_q.den <= quo_q[30:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/rational_arith_unit.sv
// top level: rational arithmetic unit with gcd reduction
//
// channel  direction  handshake         payload
// in       input      in_valid/in_stall command a_num a_den b_num b_den
// out      output     out_valid/out_stall result_num result_den is_equal status
//
// an item runs a binary gcd over 64-bit values, then two divisions by the
// gcd, first of the numerator and then of the denominator.
// error, compare and zero-numerator items end early and skip the divisions.
// reset clears the state machine, the front valid flag and the queue pointers.
// the queue and the front register let the front accept three more beats
// while the back works.
`default_nettype none
module rational_arith_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] a_num,
	input  wire logic [31:0] a_den,
	input  wire logic [31:0] b_num,
	input  wire logic [31:0] b_den,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] result_num,
	output logic [30:0]      result_den,
	output logic             is_equal,
	output logic [1:0]       status
);
	import rau_pkg::*;

	job_t f_job, q_job;
	logic f_valid, f_stall, q_valid, q_take;
	res_t res;

	rau_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .a_num, .a_den,
		.b_num, .b_den, .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
	);

	rau_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
		.rd_valid(q_valid), .rd_take(q_take), .rd_data(q_job)
	);

	rau_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job_take(q_take), .job(q_job),
		.out_valid, .out_stall, .res
	);

	assign result_num = res.num;
	assign result_den = res.den;
	assign is_equal   = res.is_eq;
	assign status     = res.status;

	// an equal compare result never carries a fraction
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> result_den == '0 && status == ST_OK)
		else $error("compare beat carries a fraction");
	// a good arithmetic result with a nonzero numerator has a positive denominator
	a_pos_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && !is_equal && result_num != '0
		|-> result_den != '0)
		else $error("zero denominator on good result");
	// an error or overflow result has a zero numerator and no equal flag
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_num == '0 && !is_equal)
		else $error("error beat has data");
endmodule
`default_nettype wire
